FILE: rtl/dbscan_pkg.sv
// Shared types, command and status bundles, and constants for the DBSCAN clusterer.
`default_nettype none
package dbscan_pkg;

    localparam int RADIUS_W   = 34;
    localparam int MINPTS_W   = 7;
    localparam int LABEL_W    = 7;
    localparam int OUT_IDX_W  = 6;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MINPTS = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 34'd100;
    localparam logic [MINPTS_W-1:0] MINPTS_RESET = 7'd4;
    localparam logic [LABEL_W-1:0]  FIRST_CLUSTER = 7'd1;
    localparam logic [LABEL_W-1:0]  NOISE_LABEL   = 7'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PSEL,
        ST_PREF,
        ST_PSCAN,
        ST_PDEC,
        ST_XWAIT,
        ST_QCHK,
        ST_QLD,
        ST_SREF,
        ST_SSCAN,
        ST_SDEC,
        ST_ORD,
        ST_OSHOW
    } state_t;

    typedef enum logic [1:0] {
        MODE_COUNT,
        MODE_CORE,
        MODE_SEED
    } scan_mode_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       p_inc;
        logic       ref_rd;
        logic       ref_seed;
        logic       ref_ld;
        logic       scan_start;
        scan_mode_t mode;
        logic       mark_noise;
        logic       q_reset;
        logic       q_rd;
        logic       cluster_inc;
        logic       out_start;
        logic       out_rd;
        logic       k_inc;
        logic       out_done;
    } cmd_t;

    typedef struct packed {
        logic p_done;
        logic p_labelled;
        logic scan_busy;
        logic core;
        logic q_empty;
        logic out_last;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/dbscan_ctrl.sv
// Sequencer for load, neighborhood scans, seed expansion and label readout.
`default_nettype none
module dbscan_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  wire                   in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    input  dbscan_pkg::status_t   status,
    output dbscan_pkg::cmd_t      cmd
);

    dbscan_pkg::state_t state_reg;
    dbscan_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbscan_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mode   = dbscan_pkg::MODE_COUNT;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            dbscan_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = dbscan_pkg::ST_CLEAR;
                    end
                end
            end
            dbscan_pkg::ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = dbscan_pkg::ST_PSEL;
            end
            dbscan_pkg::ST_PSEL:
            begin
                priority if (status.p_done)
                begin
                    cmd.out_start = 1'b1;
                    state_next    = dbscan_pkg::ST_ORD;
                end
                else if (status.p_labelled)
                begin
                    cmd.p_inc = 1'b1;
                end
                else
                begin
                    cmd.ref_rd = 1'b1;
                    state_next = dbscan_pkg::ST_PREF;
                end
            end
            dbscan_pkg::ST_PREF:
            begin
                cmd.ref_ld     = 1'b1;
                cmd.scan_start = 1'b1;
                cmd.mode       = dbscan_pkg::MODE_COUNT;
                state_next     = dbscan_pkg::ST_PSCAN;
            end
            dbscan_pkg::ST_PSCAN:
            begin
                if (!status.scan_busy)
                begin
                    state_next = dbscan_pkg::ST_PDEC;
                end
            end
            dbscan_pkg::ST_PDEC:
            begin
                if (!status.core)
                begin
                    cmd.mark_noise = 1'b1;
                    cmd.p_inc      = 1'b1;
                    state_next     = dbscan_pkg::ST_PSEL;
                end
                else
                begin
                    cmd.q_reset    = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.mode       = dbscan_pkg::MODE_CORE;
                    state_next     = dbscan_pkg::ST_XWAIT;
                end
            end
            dbscan_pkg::ST_XWAIT:
            begin
                if (!status.scan_busy)
                begin
                    state_next = dbscan_pkg::ST_QCHK;
                end
            end
            dbscan_pkg::ST_QCHK:
            begin
                if (status.q_empty)
                begin
                    cmd.cluster_inc = 1'b1;
                    cmd.p_inc       = 1'b1;
                    state_next      = dbscan_pkg::ST_PSEL;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = dbscan_pkg::ST_QLD;
                end
            end
            dbscan_pkg::ST_QLD:
            begin
                cmd.ref_rd   = 1'b1;
                cmd.ref_seed = 1'b1;
                state_next   = dbscan_pkg::ST_SREF;
            end
            dbscan_pkg::ST_SREF:
            begin
                cmd.ref_ld     = 1'b1;
                cmd.scan_start = 1'b1;
                cmd.mode       = dbscan_pkg::MODE_COUNT;
                state_next     = dbscan_pkg::ST_SSCAN;
            end
            dbscan_pkg::ST_SSCAN:
            begin
                if (!status.scan_busy)
                begin
                    state_next = dbscan_pkg::ST_SDEC;
                end
            end
            dbscan_pkg::ST_SDEC:
            begin
                if (!status.core)
                begin
                    state_next = dbscan_pkg::ST_QCHK;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.mode       = dbscan_pkg::MODE_SEED;
                    state_next     = dbscan_pkg::ST_XWAIT;
                end
            end
            dbscan_pkg::ST_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = dbscan_pkg::ST_OSHOW;
            end
            dbscan_pkg::ST_OSHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        cmd.out_done = 1'b1;
                        state_next   = dbscan_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = dbscan_pkg::ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = dbscan_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/dbscan_dp.sv
// Datapath: point and label memories, distance pipeline, seed queue and counters.
`default_nettype none
module dbscan_dp
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
)
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire [COORD_BITS-1:0]                  in_x,
    input  wire [COORD_BITS-1:0]                  in_y,
    input  wire                                   cfg_we,
    input  wire [dbscan_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [dbscan_pkg::RADIUS_W-1:0]        cfg_data,
    input  dbscan_pkg::cmd_t                      cmd,
    output dbscan_pkg::status_t                   status,
    output logic [dbscan_pkg::OUT_IDX_W-1:0]      out_index,
    output logic [dbscan_pkg::LABEL_W-1:0]        out_label
);

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int DW   = COORD_BITS + 1;
    localparam int SQW  = 2 * DW;
    localparam int SW   = SQW + 1;
    localparam int CMPW = (SW > dbscan_pkg::RADIUS_W) ? SW : dbscan_pkg::RADIUS_W;

    logic [dbscan_pkg::RADIUS_W-1:0] radius_reg;
    logic [dbscan_pkg::MINPTS_W-1:0] minpts_reg;

    logic [2*COORD_BITS-1:0] xy_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] rd_xy_reg;
    logic [dbscan_pkg::LABEL_W-1:0] lab_mem [MAX_POINTS];
    logic [dbscan_pkg::LABEL_W-1:0] lab_rd_reg;
    logic [IW-1:0] q_mem [MAX_POINTS];
    logic [IW-1:0] qdata_reg;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] p_reg;
    logic [IW-1:0] k_reg;
    logic [CW-1:0] head_reg;
    logic [CW-1:0] tail_reg;
    logic [dbscan_pkg::LABEL_W-1:0] cluster_reg;
    logic [CW-1:0] ncnt_reg;
    logic [MAX_POINTS-1:0] labelled_reg;
    logic [MAX_POINTS-1:0] noise_reg;

    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic [IW-1:0] ref_idx_reg;

    logic                   iss_reg;
    logic [CW-1:0]          si_reg;
    dbscan_pkg::scan_mode_t mode_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   v4_reg;
    logic [IW-1:0]          idx1_reg;
    logic [IW-1:0]          idx2_reg;
    logic [IW-1:0]          idx3_reg;
    logic [IW-1:0]          idx4_reg;
    logic [DW-1:0]          dx_reg;
    logic [DW-1:0]          dy_reg;
    logic [SQW-1:0]         sqx_reg;
    logic [SQW-1:0]         sqy_reg;
    logic                   near_reg;

    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic [DW-1:0] dx_raw;
    logic [DW-1:0] dy_raw;
    logic [SW-1:0] dist_sum;

    logic                          hit;
    logic                          set_lab;
    logic                          clr_noise;
    logic                          enq;
    logic                          lab_we;
    logic [IW-1:0]                 lab_wa;
    logic [dbscan_pkg::LABEL_W-1:0] lab_wd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= dbscan_pkg::RADIUS_RESET;
            minpts_reg <= dbscan_pkg::MINPTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbscan_pkg::REG_RADIUS: radius_reg <= cfg_data;
                dbscan_pkg::REG_MINPTS: minpts_reg <= cfg_data[dbscan_pkg::MINPTS_W-1:0];
                default: ;
            endcase
        end
    end

    assign rd_en   = iss_reg | cmd.ref_rd;
    assign rd_addr = iss_reg ? si_reg[IW-1:0] : (cmd.ref_seed ? qdata_reg : p_reg[IW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load && (cnt_reg != CW'(MAX_POINTS)))
        begin
            xy_mem[cnt_reg[IW-1:0]] <= {in_y, in_x};
        end
        if (rd_en)
        begin
            rd_xy_reg <= xy_mem[rd_addr];
        end
        if (cmd.ref_rd)
        begin
            ref_idx_reg <= rd_addr;
        end
        if (cmd.ref_ld)
        begin
            px_reg <= rd_xy_reg[COORD_BITS-1:0];
            py_reg <= rd_xy_reg[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // distance pipeline: absolute differences, squares, sum and compare
    always_comb
    begin
        logic [DW-1:0] ddx;
        logic [DW-1:0] ddy;
        ddx = {rd_xy_reg[COORD_BITS-1], rd_xy_reg[COORD_BITS-1:0]}
            - {px_reg[COORD_BITS-1], px_reg};
        ddy = {rd_xy_reg[2*COORD_BITS-1], rd_xy_reg[2*COORD_BITS-1:COORD_BITS]}
            - {py_reg[COORD_BITS-1], py_reg};
        dx_raw = ddx[DW-1] ? (~ddx + DW'(1)) : ddx;
        dy_raw = ddy[DW-1] ? (~ddy + DW'(1)) : ddy;
    end

    assign dist_sum = SW'(sqx_reg) + SW'(sqy_reg);

    always_ff @(posedge clk)
    begin
        idx1_reg <= si_reg[IW-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        dx_reg   <= dx_raw;
        dy_reg   <= dy_raw;
        sqx_reg  <= SQW'(dx_reg) * SQW'(dx_reg);
        sqy_reg  <= SQW'(dy_reg) * SQW'(dy_reg);
        near_reg <= CMPW'(dist_sum) <= CMPW'(radius_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg  <= 1'b0;
            si_reg   <= '0;
            mode_reg <= dbscan_pkg::MODE_COUNT;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end
        else
        begin
            v1_reg <= iss_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.scan_start)
            begin
                iss_reg  <= 1'b1;
                si_reg   <= '0;
                mode_reg <= cmd.mode;
            end
            else if (iss_reg)
            begin
                si_reg <= si_reg + CW'(1);
                if (si_reg == cnt_reg - CW'(1))
                begin
                    iss_reg <= 1'b0;
                end
            end
        end
    end

    // act on each neighbor as it leaves the pipeline
    always_comb
    begin
        hit       = v4_reg & near_reg;
        set_lab   = 1'b0;
        clr_noise = 1'b0;
        enq       = 1'b0;
        lab_we    = 1'b0;
        lab_wa    = idx4_reg;
        lab_wd    = cluster_reg;
        unique case (mode_reg)
            dbscan_pkg::MODE_COUNT: ;
            dbscan_pkg::MODE_CORE:
            begin
                if (hit)
                begin
                    set_lab   = 1'b1;
                    clr_noise = 1'b1;
                    lab_we    = 1'b1;
                    enq       = (idx4_reg != ref_idx_reg);
                end
            end
            dbscan_pkg::MODE_SEED:
            begin
                if (hit)
                begin
                    if (!labelled_reg[idx4_reg])
                    begin
                        set_lab = 1'b1;
                        lab_we  = 1'b1;
                        enq     = 1'b1;
                    end
                    else if (noise_reg[idx4_reg])
                    begin
                        clr_noise = 1'b1;
                        lab_we    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (cmd.mark_noise)
        begin
            lab_we = 1'b1;
            lab_wa = p_reg[IW-1:0];
            lab_wd = dbscan_pkg::NOISE_LABEL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_wa] <= lab_wd;
        end
        if (cmd.out_rd)
        begin
            lab_rd_reg <= lab_mem[k_reg];
        end
        if (enq)
        begin
            q_mem[tail_reg[IW-1:0]] <= idx4_reg;
        end
        if (cmd.q_rd)
        begin
            qdata_reg <= q_mem[head_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            p_reg        <= '0;
            k_reg        <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cluster_reg  <= dbscan_pkg::FIRST_CLUSTER;
            ncnt_reg     <= '0;
            labelled_reg <= '0;
            noise_reg    <= '0;
        end
        else
        begin
            if (cmd.load && (cnt_reg != CW'(MAX_POINTS)))
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.out_done)
            begin
                cnt_reg <= '0;
            end
            if (cmd.clear)
            begin
                p_reg        <= '0;
                cluster_reg  <= dbscan_pkg::FIRST_CLUSTER;
                labelled_reg <= '0;
                noise_reg    <= '0;
            end
            else
            begin
                if (cmd.p_inc)
                begin
                    p_reg <= p_reg + CW'(1);
                end
                if (cmd.cluster_inc)
                begin
                    cluster_reg <= cluster_reg + dbscan_pkg::LABEL_W'(1);
                end
                if (cmd.mark_noise)
                begin
                    labelled_reg[p_reg[IW-1:0]] <= 1'b1;
                    noise_reg[p_reg[IW-1:0]]    <= 1'b1;
                end
                if (set_lab)
                begin
                    labelled_reg[idx4_reg] <= 1'b1;
                end
                if (clr_noise)
                begin
                    noise_reg[idx4_reg] <= 1'b0;
                end
            end
            if (cmd.scan_start)
            begin
                ncnt_reg <= '0;
            end
            else if (hit && (mode_reg == dbscan_pkg::MODE_COUNT))
            begin
                ncnt_reg <= ncnt_reg + CW'(1);
            end
            if (cmd.q_reset)
            begin
                head_reg <= '0;
                tail_reg <= '0;
            end
            else
            begin
                if (cmd.q_rd)
                begin
                    head_reg <= head_reg + CW'(1);
                end
                if (enq)
                begin
                    tail_reg <= tail_reg + CW'(1);
                end
            end
            if (cmd.out_start)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + IW'(1);
            end
        end
    end

    assign status.p_done     = (p_reg == cnt_reg);
    assign status.p_labelled = labelled_reg[p_reg[IW-1:0]];
    assign status.scan_busy  = iss_reg | v1_reg | v2_reg | v3_reg | v4_reg;
    assign status.core       = dbscan_pkg::MINPTS_W'(ncnt_reg) >= minpts_reg;
    assign status.q_empty    = (head_reg == tail_reg);
    assign status.out_last   = ((CW'(k_reg) + CW'(1)) == cnt_reg);

    assign out_index = dbscan_pkg::OUT_IDX_W'(k_reg);
    assign out_label = lab_rd_reg;

endmodule
`default_nettype wire

FILE: rtl/dbscan_point_clusterer.sv
// Points load while the block is idle; the last one starts a pass over the n stored points:
// a clear step, a skip per labelled point, a count scan per visited point and per seed, an
// expansion scan per core point, a cluster step per finished cluster, then the label beats.
// Throughput: scans stream one stored point per cycle through a four-stage distance pipe.
// Reset: asynchronous active low; clears counters, queue pointers and flags, and loads
// radius_squared = 100 and min_points = 4. Memories are not cleared.
`default_nettype none
module dbscan_point_clusterer
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
)
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    // x_coord, y_coord, zero pad
    input  wire [((2*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    input  wire                                     s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    // point_index, cluster_label, zero pad
    output logic [dbscan_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                    m_axis_tlast,
    input  wire                                     cfg_we,
    input  wire [dbscan_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [dbscan_pkg::RADIUS_W-1:0]          cfg_data
);

    localparam int PAD_W = dbscan_pkg::OUT_TDATA_W - dbscan_pkg::OUT_IDX_W
                         - dbscan_pkg::LABEL_W;

    dbscan_pkg::cmd_t    cmd;
    dbscan_pkg::status_t status;
    logic [dbscan_pkg::OUT_IDX_W-1:0] out_index;
    logic [dbscan_pkg::LABEL_W-1:0]   out_label;

    dbscan_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dbscan_dp
    #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_x      (s_axis_tdata[COORD_BITS-1:0]),
        .in_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_index (out_index),
        .out_label (out_label)
    );

    assign m_axis_tdata = {PAD_W'(0), out_label, out_index};
    assign m_axis_tlast = status.out_last;

`ifndef SYNTHESIS
    // loading and label readout never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a label beat is pending");

    // the final label beat returns the block to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not ready after final label beat");

    // a label beat follows its read only when no scan is running
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !status.scan_busy)
        else $error("label beat shown during a neighborhood scan");
`endif

endmodule
`default_nettype wire
